// ===== hdl/tkrt_pkg.sv =====
package tkrt_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 10;
    localparam int KEY_W               = 64;

    // One stored record; the first member sits in the highest bits, so the
    // record id lands in bit 0 upward when the struct is used as tdata.
    typedef struct packed {
        logic [15:0] payload;
        logic [31:0] secondary_key;
        logic [31:0] primary_key;
        logic [31:0] record_id;
    } record_t;

    localparam int REC_W = $bits(record_t);

    typedef struct packed {
        logic capture;
        logic rd_en;
        logic best_init;
        logic best_scan;
        logic commit;
        logic cur_load;
        logic cur_swap;
        logic emit;
        logic last;
    } cmd_t;

    typedef struct packed {
        logic has_empty;
        logic out_free;
    } status_t;

    // Mode 1 key is primary * (2^32 - 1) + secondary; it always fits in
    // 64 signed bits, so modulo-2^64 arithmetic gives the exact value.
    function automatic logic signed [KEY_W-1:0] sort_key(input logic mode,
                                                         input record_t rec);
        logic [KEY_W-1:0] p_ext;
        logic [KEY_W-1:0] scaled;
        p_ext  = {{32{rec.primary_key[31]}}, rec.primary_key};
        scaled = {rec.primary_key, 32'h0} - p_ext + {32'h0, rec.secondary_key};
        if (mode)
        begin
            return $signed(scaled);
        end
        return $signed(p_ext);
    endfunction

endpackage

// ===== hdl/tkrt_ctrl.sv =====
module tkrt_ctrl #(
    parameter int TABLE_DEPTH = tkrt_pkg::DEFAULT_TABLE_DEPTH,
    parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               req_type,
    input  tkrt_pkg::status_t  status,
    output tkrt_pkg::cmd_t     cmd,
    output logic [IDX_W-1:0]   rd_addr,
    output logic [IDX_W-1:0]   scan_idx,
    output logic [IDX_W-1:0]   pos_idx
);
    import tkrt_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    typedef enum logic [5:0] {
        ST_IDLE        = 6'b000001,
        ST_OFFER_SCAN  = 6'b000010,
        ST_OFFER_WRITE = 6'b000100,
        ST_PASS_HEAD   = 6'b001000,
        ST_PASS_SCAN   = 6'b010000,
        ST_EMIT        = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic             accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign scan_idx = scan_reg;
    assign pos_idx  = pos_reg;

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        scan_next  = scan_reg;
        cmd        = '0;
        rd_addr    = scan_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pos_next  = '0;
                    scan_next = '0;
                    if (!req_type)
                    begin
                        cmd.capture = 1'b1;
                        if (status.has_empty)
                        begin
                            cmd.best_init = 1'b1;
                            state_next    = ST_OFFER_WRITE;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            rd_addr    = '0;
                            state_next = ST_OFFER_SCAN;
                        end
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        rd_addr    = '0;
                        state_next = ST_PASS_HEAD;
                    end
                end
            end
            ST_OFFER_SCAN:
            begin
                cmd.best_scan = 1'b1;
                if (scan_reg == LAST_IDX)
                begin
                    state_next = ST_OFFER_WRITE;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    rd_addr   = scan_reg + 1'b1;
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_OFFER_WRITE:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            ST_PASS_HEAD:
            begin
                cmd.cur_load = 1'b1;
                if (pos_reg == LAST_IDX)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    rd_addr    = pos_reg + 1'b1;
                    scan_next  = pos_reg + 1'b1;
                    state_next = ST_PASS_SCAN;
                end
            end
            ST_PASS_SCAN:
            begin
                cmd.cur_swap = 1'b1;
                if (scan_reg == LAST_IDX)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    rd_addr   = scan_reg + 1'b1;
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = (pos_reg == LAST_IDX);
                    if (pos_reg == LAST_IDX)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        rd_addr    = pos_reg + 1'b1;
                        pos_next   = pos_reg + 1'b1;
                        state_next = ST_PASS_HEAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            scan_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            scan_reg  <= scan_next;
        end
    end

endmodule

// ===== hdl/tkrt_dp.sv =====
module tkrt_dp #(
    parameter int TABLE_DEPTH = tkrt_pkg::DEFAULT_TABLE_DEPTH,
    parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  tkrt_pkg::record_t  in_rec,
    input  tkrt_pkg::cmd_t     cmd,
    input  logic [IDX_W-1:0]   rd_addr,
    input  logic [IDX_W-1:0]   scan_idx,
    input  logic [IDX_W-1:0]   pos_idx,
    output tkrt_pkg::status_t  status,
    output logic               out_valid,
    input  logic               out_ready,
    output tkrt_pkg::record_t  out_rec,
    output logic               out_filled,
    output logic               out_last
);
    import tkrt_pkg::*;

    record_t                 mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  filled_reg;
    logic                    key_mode_reg;

    record_t                 rd_rec_reg;
    logic                    rd_filled_reg;
    record_t                 rd_view;
    logic signed [KEY_W-1:0] rd_key;

    record_t                 in_rec_reg;
    logic [IDX_W-1:0]        best_idx_reg;
    logic [31:0]             best_pri_reg;
    logic                    offer_wins;

    record_t                 cur_rec_reg;
    logic                    cur_filled_reg;
    logic signed [KEY_W-1:0] cur_key_reg;
    logic                    swap_hit;

    logic                    out_valid_reg;
    record_t                 out_rec_reg;
    logic                    out_filled_reg;
    logic                    out_last_reg;

    logic                    mem_we;
    logic [IDX_W-1:0]        wr_addr;
    record_t                 wr_data;
    logic [IDX_W-1:0]        first_empty;

    // Lowest empty slot; has_empty tells whether there is one.
    always_comb
    begin
        first_empty = '0;
        for (int k = TABLE_DEPTH - 1; k >= 0; k--)
        begin
            if (!filled_reg[k])
            begin
                first_empty = IDX_W'(k);
            end
        end
    end

    assign status.has_empty = ~&filled_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    // Empty slots read as all zero.
    assign rd_view    = rd_filled_reg ? rd_rec_reg : '0;
    assign rd_key     = sort_key(key_mode_reg, rd_view);
    assign swap_hit   = rd_key > cur_key_reg;
    assign offer_wins = $signed(in_rec_reg.primary_key) > $signed(best_pri_reg);

    always_comb
    begin
        mem_we  = 1'b0;
        wr_addr = scan_idx;
        wr_data = cur_rec_reg;
        if (cmd.commit && offer_wins)
        begin
            mem_we  = 1'b1;
            wr_addr = best_idx_reg;
            wr_data = in_rec_reg;
        end
        else if (cmd.cur_swap && swap_hit)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_rec_reg    <= mem[rd_addr];
            rd_filled_reg <= filled_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg   <= '0;
            key_mode_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                key_mode_reg <= cfg_wr_data;
            end
            if (cmd.commit && offer_wins)
            begin
                filled_reg[best_idx_reg] <= 1'b1;
            end
            else if (cmd.cur_swap && swap_hit)
            begin
                filled_reg[scan_idx] <= cur_filled_reg;
            end
            else if (cmd.emit)
            begin
                filled_reg[pos_idx] <= 1'b0;
            end
        end
    end

    // Offer side: hold the offered record and track the replacement target.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_rec_reg <= in_rec;
        end
        if (cmd.best_init)
        begin
            best_idx_reg <= first_empty;
            best_pri_reg <= '0;
        end
        else if (cmd.best_scan)
        begin
            if (scan_idx == '0 || $signed(rd_view.primary_key) < $signed(best_pri_reg))
            begin
                best_idx_reg <= scan_idx;
                best_pri_reg <= rd_view.primary_key;
            end
        end
    end

    // Drain side: the running holder of position i during one exchange pass.
    always_ff @(posedge clk)
    begin
        if (cmd.cur_load || (cmd.cur_swap && swap_hit))
        begin
            cur_rec_reg    <= rd_view;
            cur_filled_reg <= rd_filled_reg;
            cur_key_reg    <= rd_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_rec_reg    <= cur_rec_reg;
            out_filled_reg <= cur_filled_reg;
            out_last_reg   <= cmd.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_rec    = out_rec_reg;
    assign out_filled = out_filled_reg;
    assign out_last   = out_last_reg;

endmodule

// ===== hdl/top_k_record_tracker.sv =====
// Channel   Dir  Handshake          Contents
// s_*       in   s_tvalid/s_tready  tuser: req_type; tdata: record to offer
// m_*       out  m_tvalid/m_tready  tuser: slot_valid; tdata: slot record;
//                                   tlast: last_of_run
// cfg_*     in   cfg_wr_en          cfg_wr_data: key_mode
//
// An offer goes straight to its write when the table has an empty slot; when
// it is full it first scans every slot (one table read per cycle on the
// single read port of the slot memory while hunting for the smallest primary key).
// A drain runs one exchange pass per slot and waits on m_tready before each result:
// pass i reads slots i..TABLE_DEPTH-1 once each.
// Reset clears the table and key_mode at once; no sweep follows.
// A new request is taken while the last drain result still waits on m_*.
module top_k_record_tracker #(
    parameter int TABLE_DEPTH = tkrt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // cfg
    input  logic                      cfg_wr_en,
    input  logic                      cfg_wr_data,  // key_mode
    // request stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [tkrt_pkg::REC_W-1:0] s_tdata,     // record_id, primary_key,
                                                    // secondary_key, payload
    input  logic                      s_tuser,      // req_type
    // result stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [tkrt_pkg::REC_W-1:0] m_tdata,     // out_record_id,
                                                    // out_primary_key,
                                                    // out_secondary_key,
                                                    // out_payload
    output logic                      m_tuser,      // slot_valid
    output logic                      m_tlast       // last_of_run
);
    import tkrt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    cmd_t             cmd;
    status_t          status;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] scan_idx;
    logic [IDX_W-1:0] pos_idx;
    record_t          in_rec;
    record_t          out_rec;

    // The tdata layout matches the record struct bit for bit.
    assign in_rec  = s_tdata;
    assign m_tdata = out_rec;

    // Sequencer: offer scan, exchange passes, emit handshake.
    tkrt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_type (s_tuser),
        .status   (status),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .scan_idx (scan_idx),
        .pos_idx  (pos_idx)
    );

    // Slot memory, occupancy flags, key compare and the output register.
    tkrt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_rec      (in_rec),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .scan_idx    (scan_idx),
        .pos_idx     (pos_idx),
        .status      (status),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_rec     (out_rec),
        .out_filled  (m_tuser),
        .out_last    (m_tlast)
    );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

localparam int TABLE_SLOTS = tkrt_pkg::DEFAULT_TABLE_DEPTH;

// Request kinds carried on s_tuser
localparam logic REQ_OFFER = 1'b0;
localparam logic REQ_DRAIN = 1'b1;

// key_mode settings
localparam logic KEY_PRIMARY  = 1'b0;
localparam logic KEY_COMBINED = 1'b1;

typedef struct packed {
    logic              valid;
    tkrt_pkg::record_t rec;
    logic              last;
} slot_result_t;

// Tracks the table contents and the ranked slots each drain must produce.
class ranking_checker;
    logic              filled [TABLE_SLOTS];
    tkrt_pkg::record_t slots [TABLE_SLOTS];
    logic              key_mode;
    slot_result_t      pending_ranks [$];
    int                failures;

    function new();
        clear_table();
        key_mode = KEY_PRIMARY;
        failures = 0;
    endfunction

    function void clear_table();
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            filled[i] = 1'b0;
            slots[i]  = '0;
        end
    endfunction

    // Signed 64-bit ranking key; mode 1 never overflows for 32-bit fields.
    function longint ranking_key(int idx);
        longint p;
        p = $signed(slots[idx].primary_key);
        if (key_mode == KEY_COMBINED)
        begin
            return p * 64'sd4294967295 + longint'({32'h0, slots[idx].secondary_key});
        end
        return p;
    endfunction

    function void offer(tkrt_pkg::record_t rec);
        int          target;
        logic [31:0] cur;
        target = -1;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            if (!filled[i] && target < 0)
            begin
                target = i;
            end
        end
        if (target < 0)
        begin
            target = 0;
            for (int i = 1; i < TABLE_SLOTS; i++)
            begin
                if ($signed(slots[i].primary_key) < $signed(slots[target].primary_key))
                begin
                    target = i;
                end
            end
        end
        cur = filled[target] ? slots[target].primary_key : 32'h0;
        if ($signed(rec.primary_key) > $signed(cur))
        begin
            filled[target] = 1'b1;
            slots[target]  = rec;
        end
    endfunction

    function void drain();
        logic              f;
        tkrt_pkg::record_t r;
        slot_result_t      res;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            for (int j = i + 1; j < TABLE_SLOTS; j++)
            begin
                if (ranking_key(j) > ranking_key(i))
                begin
                    f = filled[i]; filled[i] = filled[j]; filled[j] = f;
                    r = slots[i];  slots[i]  = slots[j];  slots[j]  = r;
                end
            end
        end
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            res.valid = filled[i];
            res.rec   = slots[i];
            res.last  = (i == TABLE_SLOTS - 1);
            pending_ranks.push_back(res);
        end
        clear_table();
    endfunction

    function void note_request(logic kind, tkrt_pkg::record_t rec);
        if (kind == REQ_DRAIN)
        begin
            drain();
        end
        else
        begin
            offer(rec);
        end
    endfunction

    function void check_slot(logic valid, tkrt_pkg::record_t rec, logic last);
        slot_result_t want;
        if (pending_ranks.size() == 0)
        begin
            if (failures < 10)
            begin
                $display("unexpected slot: valid=%0b id=%h pk=%h sk=%h pay=%h last=%0b",
                         valid, rec.record_id, rec.primary_key, rec.secondary_key,
                         rec.payload, last);
            end
            failures++;
            return;
        end
        want = pending_ranks.pop_front();
        if (want.valid !== valid || want.last !== last
            || want.rec.record_id !== rec.record_id
            || want.rec.primary_key !== rec.primary_key
            || want.rec.secondary_key !== rec.secondary_key
            || want.rec.payload !== rec.payload)
        begin
            if (failures < 10)
            begin
                $display("slot mismatch: expected valid=%0b id=%h pk=%h sk=%h pay=%h last=%0b",
                         want.valid, want.rec.record_id, want.rec.primary_key,
                         want.rec.secondary_key, want.rec.payload, want.last);
                $display("               actual   valid=%0b id=%h pk=%h sk=%h pay=%h last=%0b",
                         valid, rec.record_id, rec.primary_key, rec.secondary_key,
                         rec.payload, last);
            end
            failures++;
        end
    endfunction
endclass

module testbench;

    // Give up well beyond the slowest legal run: every offer hunting a full
    // table, every drain stalled by the receiver, plus the long hold-off.
    localparam int CYCLE_LIMIT   = 400000;
    // Quiet time before a register write or the final verdict; covers an
    // offer that is still scanning a full table after the last result.
    localparam int SETTLE_CYCLES = 2 * TABLE_SLOTS + 4;
    localparam int PHASE_ITEMS   = 56;

    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       cfg_wr_en   = 1'b0;
    logic                       cfg_wr_data = 1'b0;
    logic                       s_tvalid    = 1'b0;
    logic                       s_tready;
    logic [tkrt_pkg::REC_W-1:0] s_tdata     = '0;   // record_id, primary_key,
                                                    // secondary_key, payload
    logic                       s_tuser     = 1'b0; // req_type
    logic                       m_tvalid;
    logic                       m_tready    = 1'b0;
    logic [tkrt_pkg::REC_W-1:0] m_tdata;            // out_record_id, out_primary_key,
                                                    // out_secondary_key, out_payload
    logic                       m_tuser;            // slot_valid
    logic                       m_tlast;            // last_of_run

    ranking_checker sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int rx_hold        = 0;
    int cycle_count    = 0;
    int requests_sent  = 0;

    always #1 clk = ~clk;

    top_k_record_tracker #(
        .TABLE_DEPTH (TABLE_SLOTS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // Watchdog: abort a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Check every slot the block hands over against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_slot(m_tuser, m_tdata, m_tlast);
        end
    end

    // Receiver: hold off for the requested number of cycles first, otherwise
    // stall at random with the phase's percentage.
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Present one request and hold it until the block takes it. Leave valid
    // high afterwards; the next call or wait_idle decides at the next
    // falling edge whether it drops.
    task automatic send_request(input logic kind, input tkrt_pkg::record_t rec);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= rec;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        sb.note_request(kind, rec);
        requests_sent++;
    endtask

    task automatic offer_record(input logic [31:0] id, input logic [31:0] pk,
                                input logic [31:0] sk, input logic [15:0] pay);
        tkrt_pkg::record_t rec;
        rec.record_id     = id;
        rec.primary_key   = pk;
        rec.secondary_key = sk;
        rec.payload       = pay;
        send_request(REQ_OFFER, rec);
    endtask

    // Drain with random junk on tdata; the block must ignore it.
    task automatic drain_table();
        tkrt_pkg::record_t junk;
        junk.record_id     = $urandom;
        junk.primary_key   = $urandom;
        junk.secondary_key = $urandom;
        junk.payload       = 16'($urandom);
        send_request(REQ_DRAIN, junk);
    endtask

    // Random offer: mix narrow key ranges (ties, rejections at or below zero)
    // with full-range and boundary keys; secondary keys include the extremes
    // that make different pairs collide in combined mode.
    function automatic tkrt_pkg::record_t random_offer();
        tkrt_pkg::record_t r;
        r.record_id = $urandom;
        r.payload   = 16'($urandom);
        case ($urandom_range(3))
            0: r.primary_key = $urandom_range(15) - 3;
            1: r.primary_key = $urandom;
            2:
            begin
                case ($urandom_range(4))
                    0: r.primary_key = 32'h7FFF_FFFF;
                    1: r.primary_key = 32'h8000_0000;
                    2: r.primary_key = 32'h0000_0000;
                    3: r.primary_key = 32'h0000_0001;
                    default: r.primary_key = 32'hFFFF_FFFF;
                endcase
            end
            default: r.primary_key = $urandom_range(1000, 1);
        endcase
        case ($urandom_range(2))
            0: r.secondary_key = $urandom;
            1: r.secondary_key = $urandom_range(3);
            default: r.secondary_key = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
        endcase
        return r;
    endfunction

    // Drop valid, let every predicted slot arrive, then give the block time
    // to finish any offer it may still be working on.
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending_ranks.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_key_mode(input logic mode);
        wait_idle();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        sb.key_mode = mode;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Random phase: bursts of offers, each closed by a drain. A burst of
    // zero gives back-to-back drains. With pressure set, stall the receiver
    // for a long stretch right after a drain so requests back up.
    task automatic run_phase(input int idle_pct, input int stall_pct,
                             input logic mode, input bit pressure);
        int target;
        int burst;
        write_key_mode(mode);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = requests_sent + PHASE_ITEMS;
        if (pressure)
        begin
            repeat (12) send_request(REQ_OFFER, random_offer());
            drain_table();
            rx_hold = 300;
        end
        while (requests_sent < target)
        begin
            burst = $urandom_range(24);
            repeat (burst) send_request(REQ_OFFER, random_offer());
            drain_table();
        end
    endtask

    initial
    begin
        int unsigned warm_keys [9] = '{5, 3, 5, 1, 9, 3, 1, 2, 8};

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, primary-key ranking, no idling.
        write_key_mode(KEY_PRIMARY);
        drain_table();                                          // empty table
        offer_record(32'h0000_0001, 32'h0000_0000, 32'h1, 16'h0001); // zero: rejected
        offer_record(32'h0000_0002, 32'h8000_0000, 32'h2, 16'h0002); // most negative
        offer_record(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        foreach (warm_keys[k])
        begin
            offer_record(32'h100 + k, warm_keys[k], 32'h0, 16'h0);
        end
        offer_record(32'h0000_0200, 32'd1, 32'h5, 16'h1234);   // equal to min: rejected
        offer_record(32'h0000_0201, 32'd4, 32'h6, 16'h4321);   // replaces earliest min
        offer_record(32'h0000_0202, 32'hFFFF_FFFF, 32'h7, 16'h5555);
        drain_table();                                          // equal keys never swap

        // Directed, combined ranking: (5, all-ones) and (6, 0) rank equal.
        write_key_mode(KEY_COMBINED);
        offer_record(32'h0000_0300, 32'd6, 32'h0000_0000, 16'h0300);
        offer_record(32'h0000_0301, 32'd5, 32'hFFFF_FFFF, 16'h0301);
        offer_record(32'h0000_0302, 32'd5, 32'h0000_0000, 16'h0302);
        offer_record(32'h0000_0303, 32'd5, 32'h0000_0007, 16'h0303);
        offer_record(32'h0000_0304, 32'h7FFF_FFFF, 32'h0000_0000, 16'h0304);
        offer_record(32'h0000_0305, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'h0305);
        offer_record(32'h0000_0306, 32'd1, 32'hFFFF_FFFF, 16'h0306);
        drain_table();

        // Random phases across idling patterns and both key modes.
        run_phase(0,  0,  KEY_COMBINED, 1'b0);
        run_phase(47, 0,  KEY_PRIMARY,  1'b0);
        run_phase(0,  47, KEY_COMBINED, 1'b0);
        run_phase(23, 23, KEY_PRIMARY,  1'b0);
        run_phase(0,  0,  KEY_COMBINED, 1'b1);

        wait_idle();
        if (sb.failures == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
